@@ rtl/cmf_pkg.sv @@
package cmf_pkg;

  localparam int MaxWidthDefault = 2048;
  localparam int WidthBits = 12;
  localparam logic [WidthBits-1:0] ImageWidthReset = 12'd640;
  localparam int AddrBits = 3;
  localparam logic RegImageWidth = 1'b0;

  localparam logic CmdFlush = 1'b1;

  localparam int QueueDepth = 4;
  localparam int CountBits = $clog2(QueueDepth + 1);

  localparam int Slots = 5;
  localparam int SlotMid = 0;
  localparam int SlotUp = 1;
  localparam int SlotPix = 2;
  localparam int SlotLeft = 3;
  localparam int SlotNext = 4;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       row_end;
    logic       image_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t PixOnes = '1;
  localparam pixel_t PixZero = '0;

  typedef pixel_t [Slots-1:0] slots_t;

  typedef struct packed {
    slots_t px;
    logic   row_end;
    logic   image_end;
  } job_t;

  typedef logic [Slots-1:0][7:0] quint_t;
  typedef logic [3:0][7:0] quad_t;

  function automatic logic [7:0] min8(logic [7:0] a, logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max8(logic [7:0] a, logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  // First three layers of a five-input sorting network. The smallest
  // value is dropped since the median never needs it.
  function automatic quad_t sort_front(quint_t v);
    logic [7:0] s0, s1, s2, s3, s4;
    logic [7:0] t0, t1, t2, t3, t4;
    quad_t      q;
    s0 = min8(v[0], v[3]);
    s3 = max8(v[0], v[3]);
    s1 = min8(v[1], v[4]);
    s4 = max8(v[1], v[4]);
    s2 = v[2];
    t0 = min8(s0, s2);
    t2 = max8(s0, s2);
    t1 = min8(s1, s3);
    t3 = max8(s1, s3);
    t4 = s4;
    q[0] = max8(t0, t1);
    q[1] = min8(t2, t4);
    q[2] = t3;
    q[3] = max8(t2, t4);
    return q;
  endfunction

  function automatic logic [7:0] median_back(quad_t q);
    return min8(max8(q[0], q[1]), min8(q[2], q[3]));
  endfunction

endpackage

@@ rtl/cmf_front.sv @@
module cmf_front import cmf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WidthBits-1:0] width_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  input  logic [CountBits-1:0] q_count_i,
  output logic                 push_o,
  output job_t                 push_job_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > WidthBits) ? CW + 1 : WidthBits;

  typedef struct packed {
    logic               flush;
    logic               produce;
    logic               row_end;
    logic               image_end;
    logic [CW-1:0]      col;
    pixel_t             pix;
    logic [Slots-1:1]   present;
    logic [Slots-1:1]   pad_hi;
  } front_slot_t;

  logic [CW-1:0] col_q, col_d;
  logic [1:0]    rows_q, rows_d;
  logic          a_valid_q;
  front_slot_t   a_q, a_d;
  pixel_t        left_q;

  pixel_t mid_mem [MAX_WIDTH];
  pixel_t up_mem [MAX_WIDTH];
  pixel_t mid_c_q, mid_n_q, up_c_q;

  logic [LW-1:0] width_ext, wact, col_ext, c_ext;
  logic [CW-1:0] c, c_next;
  logic          last, flush, accept, act, up_we;
  logic          miss_up, miss_pix, miss_left, miss_next;
  pixel_t        pix_in;

  assign width_ext = LW'(width_i);
  assign col_ext = LW'(col_q);

  always_comb begin
    if (width_ext == '0) begin
      wact = LW'(1);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      wact = LW'(MAX_WIDTH);
    end else begin
      wact = width_ext;
    end
  end

  assign c_ext = (col_ext >= wact) ? wact - LW'(1) : col_ext;
  assign c = c_ext[CW-1:0];
  assign c_next = c + CW'(1);
  assign last = (c_ext + LW'(1)) >= wact;

  assign in_ready_o = ({1'b0, q_count_i} + (CountBits + 1)'(a_valid_q))
                      < (CountBits + 1)'(QueueDepth);
  assign accept = in_valid_i & in_ready_o;
  assign flush = in_word_i.command == CmdFlush;
  assign act = accept & ~(flush & (rows_q == 2'd0));

  assign pix_in = '{
    alpha: in_word_i.alpha_in,
    blue:  in_word_i.blue_in,
    green: in_word_i.green_in,
    red:   in_word_i.red_in
  };

  // Missing neighbors are padded alternately with all ones and all zeros,
  // starting with ones, so a five-input median yields the upper median.
  assign miss_up = rows_q != 2'd2;
  assign miss_pix = flush;
  assign miss_left = c == '0;
  assign miss_next = last;

  always_comb begin
    a_d = a_q;
    a_d.flush = flush;
    a_d.produce = rows_q != 2'd0;
    a_d.row_end = last;
    a_d.image_end = last & flush;
    a_d.col = c;
    a_d.pix = pix_in;
    a_d.present[SlotUp] = ~miss_up;
    a_d.present[SlotPix] = ~miss_pix;
    a_d.present[SlotLeft] = ~miss_left;
    a_d.present[SlotNext] = ~miss_next;
    a_d.pad_hi[SlotUp] = 1'b1;
    a_d.pad_hi[SlotPix] = ~miss_up;
    a_d.pad_hi[SlotLeft] = ~(miss_up ^ miss_pix);
    a_d.pad_hi[SlotNext] = ~(miss_up ^ miss_pix ^ miss_left);
  end

  always_comb begin
    col_d = col_q;
    rows_d = rows_q;
    if (act) begin
      if (last) begin
        col_d = '0;
        if (flush) begin
          rows_d = 2'd0;
        end else if (rows_q != 2'd2) begin
          rows_d = rows_q + 2'd1;
        end
      end else begin
        col_d = c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      rows_q <= 2'd0;
      a_valid_q <= 1'b0;
      left_q <= PixZero;
    end else begin
      col_q <= col_d;
      rows_q <= rows_d;
      a_valid_q <= act;
      if (a_valid_q) begin
        left_q <= mid_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && !flush) begin
      mid_mem[c] <= pix_in;
    end
    if (act) begin
      mid_c_q <= mid_mem[c];
      mid_n_q <= mid_mem[c_next];
    end
  end

  // The upper row is written in the cycle after its word is accepted, once the
  // old middle entry is read; a read of that same entry takes the pending value.
  assign up_we = a_valid_q & ~a_q.flush;

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      up_mem[a_q.col] <= mid_c_q;
    end
    if (act) begin
      up_c_q <= (up_we && (a_q.col == c)) ? mid_c_q : up_mem[c];
    end
  end

  function automatic pixel_t pick(logic present, logic hi, pixel_t val);
    return present ? val : (hi ? PixOnes : PixZero);
  endfunction

  assign push_o = a_valid_q & a_q.produce;

  always_comb begin
    push_job_o.px[SlotMid] = mid_c_q;
    push_job_o.px[SlotUp] = pick(a_q.present[SlotUp], a_q.pad_hi[SlotUp], up_c_q);
    push_job_o.px[SlotPix] = pick(a_q.present[SlotPix], a_q.pad_hi[SlotPix], a_q.pix);
    push_job_o.px[SlotLeft] = pick(a_q.present[SlotLeft], a_q.pad_hi[SlotLeft], left_q);
    push_job_o.px[SlotNext] = pick(a_q.present[SlotNext], a_q.pad_hi[SlotNext], mid_n_q);
    push_job_o.row_end = a_q.row_end;
    push_job_o.image_end = a_q.image_end;
  end

endmodule

@@ rtl/cmf_queue.sv @@
module cmf_queue import cmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  job_t                 push_job_i,
  output logic [CountBits-1:0] count_o,
  output logic                 pop_valid_o,
  output job_t                 pop_job_o,
  input  logic                 pop_ready_i
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  job_t                 mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [CountBits-1:0] count_q;
  logic                 pop;

  function automatic logic [PtrBits-1:0] bump(logic [PtrBits-1:0] p);
    return (p == PtrBits'(QueueDepth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign pop_valid_o = count_q != '0;
  assign pop_job_o = mem_q[rd_q];
  assign pop = pop_valid_o & pop_ready_i;
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop) begin
        count_q <= count_q + CountBits'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/cmf_back.sv @@
module cmf_back import cmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  job_t      in_job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef struct packed {
    quad_t [3:0] ch;
    logic        row_end;
    logic        image_end;
  } sort_slot_t;

  sort_slot_t s1_q, s1_d;
  logic       s1_valid_q, s1_ready;
  logic       out_valid_q, out_ready;
  out_word_t  out_q, out_d;
  quint_t     red_v, green_v, blue_v, alpha_v;

  always_comb begin
    for (int k = 0; k < Slots; k++) begin
      red_v[k] = in_job_i.px[k].red;
      green_v[k] = in_job_i.px[k].green;
      blue_v[k] = in_job_i.px[k].blue;
      alpha_v[k] = in_job_i.px[k].alpha;
    end
  end

  always_comb begin
    s1_d.ch[0] = sort_front(red_v);
    s1_d.ch[1] = sort_front(green_v);
    s1_d.ch[2] = sort_front(blue_v);
    s1_d.ch[3] = sort_front(alpha_v);
    s1_d.row_end = in_job_i.row_end;
    s1_d.image_end = in_job_i.image_end;
  end

  always_comb begin
    out_d.red_out = median_back(s1_q.ch[0]);
    out_d.green_out = median_back(s1_q.ch[1]);
    out_d.blue_out = median_back(s1_q.ch[2]);
    out_d.alpha_out = median_back(s1_q.ch[3]);
    out_d.row_end = s1_q.row_end;
    out_d.image_end = s1_q.image_end;
  end

  assign out_ready = ~out_valid_q | out_ready_i;
  assign s1_ready = ~s1_valid_q | out_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (out_ready && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;

endmodule

@@ rtl/cross_median_filter_rgba.sv @@
// Cross-shaped median filter for RGBA pixels in raster order. Each channel
// takes the median of the pixel and its in-image up, down, left and right
// neighbors (the upper median when the count is even). The block accepts
// one word per cycle while its queue has room and emits at most one result
// per word, registered through the front stage, the queue and both sorting
// stages. The results for a row come out as the next row streams in; the
// first row of an image gives none, and one flush word per column then
// drains the last row, whose final result carries image_end. The throughput
// is set by two line stores of MAX_WIDTH pixels, each taking one write and
// up to two reads per cycle, with a five-input sorting network split over
// two stages behind a four-word queue. The line stores need no clearing
// pass after reset. The image width register lies at byte address 0;
// widths of 0 act as 1 and widths above MAX_WIDTH as MAX_WIDTH.
module cross_median_filter_rgba import cmf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [WidthBits-1:0] width_q;
  logic                 reg_sel;
  logic [CountBits-1:0] q_count;
  logic                 push, pop_valid, pop_ready;
  job_t                 push_job, pop_job;

  assign pready = 1'b1;
  assign reg_sel = paddr[AddrBits-1] == RegImageWidth;
  assign prdata = reg_sel ? 32'(width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ImageWidthReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      width_q <= pwdata[WidthBits-1:0];
    end
  end

  cmf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_job_o (push_job)
  );

  cmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .count_o     (q_count),
    .pop_valid_o (pop_valid),
    .pop_job_o   (pop_job),
    .pop_ready_i (pop_ready)
  );

  cmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_job_i    (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/cmf_checker.sv @@
module cmf_checker import cmf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_word_t            in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_word_t           out_word_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [AddrBits-1:0] paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  logic                 seen_q;
  logic [WidthBits-1:0] shadow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      shadow_q <= ImageWidthReset;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen_q <= 1'b1;
      end
      if (psel && penable && pwrite && pready && paddr[AddrBits-1] == RegImageWidth) begin
        shadow_q <= pwdata[WidthBits-1:0];
      end
    end
  end

  // A stalled result holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // An offered input word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed while waiting");

  // No result can appear before any word has been taken in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("result without any accepted input word");

  // The width register reads back the last value written to it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[AddrBits-1] == RegImageWidth |-> prdata == 32'(shadow_q))
    else $error("image width readback mismatch");

endmodule

bind cross_median_filter_rgba cmf_checker u_checker (.*);

@@ tb/cmf_median_checker.sv @@
module cmf_median_checker import cmf_pkg::*; #(
  parameter int                  MAX_WIDTH  = MaxWidthDefault,
  parameter logic [AddrBits-1:0] WIDTH_ADDR = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_word_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_word_t           out_word_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [AddrBits-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  output int                  errors_o,
  output int                  pending_o,
  output logic [1:0]          rows_buffered_o,
  output logic                frame_start_o
);

  logic [31:0]          upper_mem [MAX_WIDTH];
  logic [31:0]          middle_mem [MAX_WIDTH];
  logic [31:0]          left_px;
  int                   col;
  int                   rows_buf;
  logic [WidthBits-1:0] width_reg;
  out_word_t            median_q [$];
  int                   mismatch_count = 0;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
    end
  endtask

  function automatic logic [7:0] median_of(input logic [7:0] v [5], input int n);
    logic [7:0] s [5];
    logic [7:0] key;
    int         j;
    s = v;
    for (int i = 1; i < n; i++) begin
      key = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = key;
    end
    return s[n / 2];
  endfunction

  task automatic predict_cross_median(input in_word_t w);
    logic [31:0] px;
    logic [31:0] prev;
    logic [31:0] nb [5];
    logic [7:0]  ch [5];
    logic [7:0]  med [4];
    int          n;
    int          span;
    int          c;
    bit          flush;
    bit          last;
    out_word_t   res;
    flush = (w.command == CmdFlush);
    px = {w.alpha_in, w.blue_in, w.green_in, w.red_in};
    span = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    c = (col >= span) ? span - 1 : col;
    last = (c + 1 >= span);
    if (flush && rows_buf == 0) return;
    if (rows_buf != 0) begin
      for (int i = 0; i < 5; i++) nb[i] = '0;
      n = 0;
      nb[n] = middle_mem[c];
      n++;
      if (rows_buf >= 2) begin
        nb[n] = upper_mem[c];
        n++;
      end
      if (!flush) begin
        nb[n] = px;
        n++;
      end
      if (c > 0) begin
        nb[n] = left_px;
        n++;
      end
      if (c + 1 < span) begin
        nb[n] = middle_mem[c + 1];
        n++;
      end
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 5; i++) ch[i] = nb[i][8*k +: 8];
        med[k] = median_of(ch, n);
      end
      res.red_out   = med[0];
      res.green_out = med[1];
      res.blue_out  = med[2];
      res.alpha_out = med[3];
      res.row_end   = last;
      res.image_end = last && flush;
      median_q.push_back(res);
    end
    prev = middle_mem[c];
    if (!flush) begin
      upper_mem[c] = prev;
      middle_mem[c] = px;
    end
    left_px = prev;
    if (last) begin
      col = 0;
      if (flush) begin
        rows_buf = 0;
      end else if (rows_buf < 2) begin
        rows_buf++;
      end
    end else begin
      col = c + 1;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (median_q.size() == 0) begin
      note_mismatch("result word with nothing predicted");
      return;
    end
    want = median_q.pop_front();
    check_field("red_out", got.red_out, want.red_out);
    check_field("green_out", got.green_out, want.green_out);
    check_field("blue_out", got.blue_out, want.blue_out);
    check_field("alpha_out", got.alpha_out, want.alpha_out);
    check_field("row_end", 8'(got.row_end), 8'(want.row_end));
    check_field("image_end", 8'(got.image_end), 8'(want.image_end));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_q.delete();
      col = 0;
      rows_buf = 0;
      left_px = '0;
      width_reg = ImageWidthReset;
      pending_o <= 0;
      rows_buffered_o <= '0;
      frame_start_o <= 1'b1;
      errors_o <= mismatch_count;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_word_i);
      if (psel_i && penable_i && pready_i && paddr_i == WIDTH_ADDR) begin
        if (pwrite_i) begin
          width_reg = pwdata_i[WidthBits-1:0];
        end else if (prdata_i !== 32'(width_reg)) begin
          note_mismatch($sformatf("image_width read %0h, holds %0h", prdata_i, width_reg));
        end
      end
      if (in_valid_i && in_ready_i) predict_cross_median(in_word_i);
      pending_o <= median_q.size();
      rows_buffered_o <= 2'(rows_buf);
      frame_start_o <= (rows_buf == 0 && col == 0);
      errors_o <= mismatch_count;
    end
  end

endmodule

@@ tb/tb_cross_median_filter_rgba.sv @@
module tb_cross_median_filter_rgba;
  import cmf_pkg::*;

  localparam int                  ClkPeriod      = 12;
  localparam int                  TimeoutCycles  = 800000;
  localparam int                  SettleCycles   = 20;
  localparam int                  HoldCycles     = 300;
  localparam int                  RandomWords    = 1150;
  localparam logic                CmdPixel       = ~CmdFlush;
  localparam logic [AddrBits-1:0] ImageWidthAddr = AddrBits'(4 * RegImageWidth);

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int         errors;
  int         pending;
  logic [1:0] rows_buffered;
  logic       frame_start;

  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int span = int'(ImageWidthReset);
  int words_sent = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  cross_median_filter_rgba u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  cmf_median_checker #(
    .WIDTH_ADDR(ImageWidthAddr)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_word_i     (out_word),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .errors_o       (errors),
    .pending_o      (pending),
    .rows_buffered_o(rows_buffered),
    .frame_start_o  (frame_start)
  );

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2, 3: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t pixel_word();
    in_word_t w;
    w.command  = CmdPixel;
    w.red_in   = rand_channel();
    w.green_in = rand_channel();
    w.blue_in  = rand_channel();
    w.alpha_in = rand_channel();
    return w;
  endfunction

  function automatic in_word_t flush_word();
    in_word_t w;
    w = in_word_t'($urandom);
    w.command = CmdFlush;
    return w;
  endfunction

  function automatic in_word_t solid_word(input logic [7:0] v);
    return '{command: CmdPixel, red_in: v, green_in: v, blue_in: v, alpha_in: v};
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ImageWidthAddr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_width(input int w);
    settle();
    apb_access(1'b1, 32'(w));
    apb_access(1'b0, '0);
    span = (w == 0) ? 1 : ((w > MaxWidthDefault) ? MaxWidthDefault : w);
  endtask

  // Brings the block back to the start of an image, whatever the stream left behind.
  task automatic finish_image();
    settle();
    while (!frame_start) begin
      if (rows_buffered == 0) begin
        send_word(pixel_word());
      end else begin
        send_word(flush_word());
      end
      settle();
    end
  endtask

  // A stray flush is only placed where it reads rows that were fully written.
  task automatic send_image(input int rows, input bit with_flush, input bit synced);
    bit stray;
    stray = with_flush && ($urandom_range(0, 2) == 0);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < span; c++) begin
        if (stray && ((r == 0 && synced) || (r >= 2 && c < span - 1))
            && $urandom_range(0, 7) == 0) begin
          send_word(flush_word());
          stray = 1'b0;
        end
        send_word(pixel_word());
      end
    end
    if (with_flush) begin
      repeat (span) send_word(flush_word());
    end
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2, 3: return $urandom_range(13, 40);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    int wait_cycles;
    out_ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      wait_cycles = calm ? 0 : $urandom_range(0, 5);
      if (hold_request) begin
        wait_cycles = HoldCycles;
        hold_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("tb_cross_median_filter_rgba: errors");
    $finish;
  end

  initial begin
    int  goal;
    int  rows;
    bit  with_flush;
    bit  synced;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, '0);
    send_word(flush_word());
    write_width(3);
    send_word(solid_word(8'h00));
    send_word(solid_word(8'hff));
    send_word(pixel_word());
    send_word(solid_word(8'hff));
    send_word(pixel_word());
    send_word(solid_word(8'h00));
    send_word(pixel_word());
    send_word(flush_word());
    send_word(pixel_word());
    repeat (3) send_word(flush_word());

    // The width shrinks while the second row is half done.
    write_width(4);
    repeat (6) send_word(pixel_word());
    write_width(2);
    send_word(pixel_word());
    repeat (2) send_word(flush_word());

    write_width(0);
    send_word(solid_word(8'hff));
    send_word(solid_word(8'h00));
    send_word(flush_word());
    write_width(MaxWidthDefault);
    write_width(4095);

    write_width(24);
    calm = 1'b1;
    hold_request = 1'b1;
    send_image(4, 1'b1, 1'b1);
    finish_image();
    calm = 1'b0;

    synced = 1'b1;
    goal = RandomWords;
    while (words_sent < goal) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 6) begin
        finish_image();
        write_width(pick_width());
        synced = 1'b1;
      end
      rows = $urandom_range(1, 5);
      with_flush = ($urandom_range(0, 9) != 0);
      send_image(rows, with_flush, synced);
      if (with_flush) begin
        finish_image();
      end
      synced = with_flush;
    end
    calm = 1'b0;
    finish_image();
    settle();

    if (errors == 0) begin
      $display("tb_cross_median_filter_rgba: clean");
    end else begin
      $display("tb_cross_median_filter_rgba: errors");
    end
    $finish;
  end

endmodule
